// ----- design/ffra_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator package
// Shared sizes, status codes, header rounding and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // Table sizes and header sizes.
  localparam int MAX_EXTENTS         = 16;
  localparam int MAX_BLOCKS          = 16;
  localparam int BLOCK_HEADER_BYTES  = 24;
  localparam int REGION_HEADER_BYTES = 16;

  // Derived widths: a count holds 0..MAX_EXTENTS, an index addresses one entry.
  localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam int EIDX_W = $clog2(MAX_EXTENTS);
  localparam int BIDX_W = $clog2(MAX_BLOCKS);
  localparam int SZ_W   = 34;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Register indexes on the configuration port.
  localparam logic CFG_REGION_SIZE = 1'b0;
  localparam logic CFG_ALIGN_MASK  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_prev;
    logic       alloc_take;
    logic       shift_left;
    logic       count_dec;
    logic       blk_take;
    logic       prev_take;
    logic       merge_left;
    logic       merge_mid;
    logic       merge_right;
    logic       shift_start;
    logic       shift_right;
    logic       insert;
    logic       set_status;
    logic [1:0] code;
    logic       publish;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic idx_lt_count;
    logic fit;
    logic small_rest;
    logic slot_free;
    logic blk_hit;
    logic idx_last_blk;
    logic start_le_s;
    logic idx_nz;
    logic left_adj;
    logic right_adj;
    logic mid_adj;
    logic table_full;
    logic idx_gt_pos;
  } sts_t;

  // Round a header size up with the alignment mask.
  function automatic logic [16:0] round_hdr(input logic [6:0] hdr, input logic [15:0] mask);
    logic [16:0] t;
    t = 17'(hdr) + 17'(mask);
    return t & ~{1'b0, mask};
  endfunction

endpackage

// ----- design/first_fit_region_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator
// Keeps an address-ordered table of free extents over a byte region and
// serves allocate and free requests with splitting and coalescing.
// ----------------------------------------------------------------------------
// Usage:
// Requests come in on the in channel (func, request_size, block_address) as
// one beat each; every request gives exactly one beat on the out channel
// (status, address, free_extents). One request is in work at a time.
// An allocate scans the extents in first-fit order, moves the later entries
// down when a used-up extent leaves the table, then decides and loads the
// output register. The scan stops where the moves begin, so the two
// together stay within the table depth.
// A free first searches the block table for the block, then scans the
// extents for its place and moves entries when an extent is inserted or two
// are joined, which again add up to at most the table depth. The next
// request beat can be taken in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and its result waits until the
// register is free. Reset and every configuration write rebuild the tables
// at once (one extent after the region header, or none) and free all blocks.
// ----------------------------------------------------------------------------
module first_fit_region_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] request_size,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] address,
  output logic [4:0]  free_extents
);
  import ffra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ffra_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables and arithmetic.
  ffra_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_size  (request_size),
    .block_address (block_address),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .address       (address),
    .free_extents  (free_extents)
  );

endmodule

// ----- design/ffra_datapath.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator datapath
// Holds the registers, the extent and block tables, the scan index and the
// compare logic; acts on commands from the controller.
// ----------------------------------------------------------------------------
module ffra_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        request_size,
  input  logic [31:0]        block_address,
  input  ffra_pkg::cmd_t     cmd,
  output ffra_pkg::sts_t     sts,
  output logic [1:0]         status,
  output logic [31:0]        address,
  output logic [4:0]         free_extents
);
  import ffra_pkg::*;

  // Configuration registers.
  logic [31:0] region_size;
  logic [15:0] round_mask;

  // Free extents and allocated blocks.
  logic [31:0]           ext_start [MAX_EXTENTS];
  logic [31:0]           ext_len   [MAX_EXTENTS];
  logic [CNT_W-1:0]      ext_count;
  logic [31:0]           blk_start [MAX_BLOCKS];
  logic [31:0]           blk_len   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] blk_valid;

  // Working registers of one request.
  logic [SZ_W-1:0]   sz;
  logic [31:0]       baddr;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [31:0]       s_q;
  logic [31:0]       blen_q;
  logic [BIDX_W-1:0] found_q;
  logic [31:0]       prev_start;
  logic [31:0]       prev_len;
  logic [1:0]        res_status;
  logic [31:0]       res_addr;

  logic [CNT_W-1:0]  idx_m1;
  logic [EIDX_W-1:0] rd_addr;
  logic [EIDX_W-1:0] wr_m1;
  logic [31:0]       rd_start;
  logic [31:0]       rd_len;
  logic [BIDX_W-1:0] slot;
  logic              slot_found;
  logic [SZ_W-1:0]   sz_calc;
  logic [SZ_W-1:0]   sz_sum;
  logic [31:0]       merged_len;
  logic [31:0]       new_region;
  logic [15:0]       new_mask;
  logic [16:0]       hs;
  logic [16:0]       bs;

  // Extent read port: the current entry, or the one below it while shifting up.
  assign idx_m1   = idx - CNT_W'(1);
  assign wr_m1    = idx_m1[EIDX_W-1:0];
  assign rd_addr  = cmd.rd_prev ? wr_m1 : idx[EIDX_W-1:0];
  assign rd_start = ext_start[rd_addr];
  assign rd_len   = ext_len[rd_addr];

  // Block size: request plus header, rounded, never below one header.
  always_comb begin
    sz_sum  = SZ_W'(request_size) + SZ_W'(BLOCK_HEADER_BYTES) + SZ_W'(round_mask);
    sz_calc = sz_sum & ~SZ_W'(round_mask);
    if (sz_calc < SZ_W'(BLOCK_HEADER_BYTES)) begin
      sz_calc = SZ_W'(BLOCK_HEADER_BYTES);
    end
  end

  // First free block slot.
  always_comb begin
    slot       = '0;
    slot_found = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!blk_valid[i]) begin
        slot       = BIDX_W'(i);
        slot_found = 1'b1;
      end
    end
  end

  // Table setup values for a configuration write.
  assign new_region = (cfg_index == CFG_REGION_SIZE) ? cfg_data : region_size;
  assign new_mask   = (cfg_index == CFG_ALIGN_MASK) ? cfg_data[15:0] : round_mask;
  assign hs         = round_hdr(7'(REGION_HEADER_BYTES), new_mask);
  assign bs         = round_hdr(7'(BLOCK_HEADER_BYTES), new_mask);

  assign merged_len = prev_len + blen_q;

  // Status flags for the controller.
  always_comb begin
    sts.idx_lt_count = idx < ext_count;
    sts.fit          = SZ_W'(rd_len) >= sz;
    sts.small_rest   = (SZ_W + 1)'(rd_len) < (SZ_W + 1)'(sz) + (SZ_W + 1)'(BLOCK_HEADER_BYTES);
    sts.slot_free    = slot_found;
    sts.blk_hit      = blk_valid[idx[BIDX_W-1:0]] &&
                       (33'(blk_start[idx[BIDX_W-1:0]]) + 33'(BLOCK_HEADER_BYTES) ==
                        33'(baddr));
    sts.idx_last_blk = idx[BIDX_W-1:0] == BIDX_W'(MAX_BLOCKS - 1);
    sts.start_le_s   = rd_start <= s_q;
    sts.idx_nz       = idx != '0;
    sts.left_adj     = 33'(prev_start) + 33'(prev_len) == 33'(s_q);
    sts.right_adj    = 33'(s_q) + 33'(blen_q) == 33'(rd_start);
    sts.mid_adj      = 33'(prev_start) + 33'(prev_len) == 33'(rd_start);
    sts.table_full   = ext_count >= CNT_W'(MAX_EXTENTS);
    sts.idx_gt_pos   = idx > pos;
  end

  // Configuration, table setup and the request datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= '0;
      round_mask  <= '0;
      ext_count   <= '0;
      blk_valid   <= '0;
    end else if (cfg_write) begin
      region_size <= new_region;
      round_mask  <= new_mask;
      blk_valid   <= '0;
      if (33'(new_region) < 33'(hs) + 33'(bs)) begin
        ext_count <= '0;
      end else begin
        ext_count    <= CNT_W'(1);
        ext_start[0] <= 32'(hs);
        ext_len[0]   <= new_region - 32'(hs);
      end
    end else begin
      if (cmd.load) begin
        sz         <= sz_calc;
        baddr      <= block_address;
        idx        <= '0;
        res_status <= ST_OK;
        res_addr   <= '0;
      end
      if (cmd.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.idx_dec) begin
        idx <= idx_m1;
      end
      if (cmd.set_status) begin
        res_status <= cmd.code;
      end

      // Allocate from the hit extent, whole or split.
      if (cmd.alloc_take) begin
        blk_start[slot] <= rd_start;
        blk_valid[slot] <= 1'b1;
        res_addr        <= rd_start + 32'(BLOCK_HEADER_BYTES);
        if (sts.small_rest) begin
          blk_len[slot] <= rd_len;
        end else begin
          blk_len[slot]      <= sz[31:0];
          ext_start[rd_addr] <= rd_start + sz[31:0];
          ext_len[rd_addr]   <= rd_len - sz[31:0];
        end
      end

      // Table moves and merges; at most one of them in a cycle.
      if (cmd.shift_left) begin
        ext_start[wr_m1] <= rd_start;
        ext_len[wr_m1]   <= rd_len;
      end
      if (cmd.merge_left) begin
        ext_len[wr_m1] <= merged_len;
        prev_len       <= merged_len;
        blk_valid[found_q] <= 1'b0;
      end
      if (cmd.merge_mid) begin
        ext_len[wr_m1] <= prev_len + rd_len;
      end
      if (cmd.merge_right) begin
        ext_start[rd_addr] <= s_q;
        ext_len[rd_addr]   <= rd_len + blen_q;
        blk_valid[found_q] <= 1'b0;
      end
      if (cmd.shift_right) begin
        ext_start[idx[EIDX_W-1:0]] <= rd_start;
        ext_len[idx[EIDX_W-1:0]]   <= rd_len;
      end
      if (cmd.insert) begin
        ext_start[idx[EIDX_W-1:0]] <= s_q;
        ext_len[idx[EIDX_W-1:0]]   <= blen_q;
        ext_count          <= ext_count + CNT_W'(1);
        blk_valid[found_q] <= 1'b0;
      end
      if (cmd.count_dec) begin
        ext_count <= ext_count - CNT_W'(1);
      end

      // Free: capture the found block, then the left neighbour while scanning.
      if (cmd.blk_take) begin
        s_q     <= blk_start[idx[BIDX_W-1:0]];
        blen_q  <= blk_len[idx[BIDX_W-1:0]];
        found_q <= idx[BIDX_W-1:0];
        idx     <= '0;
      end
      if (cmd.prev_take) begin
        prev_start <= rd_start;
        prev_len   <= rd_len;
      end
      if (cmd.shift_start) begin
        pos <= idx;
        idx <= ext_count;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status       <= res_status;
      address      <= res_addr;
      free_extents <= 5'(ext_count);
    end
  end

endmodule

// ----- design/ffra_controller.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator controller
// Sequences the scans, shifts and merges of one request and drives the
// input and output handshakes.
// ----------------------------------------------------------------------------
module ffra_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  output logic           out_valid,
  input  logic           out_ready,
  input  ffra_pkg::sts_t sts,
  output ffra_pkg::cmd_t cmd
);
  import ffra_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_A_SCAN  = 3'd1;
  localparam logic [2:0] S_DROP    = 3'd2;
  localparam logic [2:0] S_F_SCAN  = 3'd3;
  localparam logic [2:0] S_F_POS   = 3'd4;
  localparam logic [2:0] S_F_MERGE = 3'd5;
  localparam logic [2:0] S_F_SHIFT = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = func ? S_F_SCAN : S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (sts.idx_lt_count && !sts.fit) begin
          cmd.idx_inc = 1'b1;
        end else if (!sts.idx_lt_count) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_NO_FIT;
          state_next     = S_OUT;
        end else if (!sts.slot_free) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_FULL;
          state_next     = S_OUT;
        end else begin
          cmd.alloc_take = 1'b1;
          if (sts.small_rest) begin
            cmd.idx_inc = 1'b1;
            state_next  = S_DROP;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_DROP: begin
        if (sts.idx_lt_count) begin
          cmd.shift_left = 1'b1;
          cmd.idx_inc    = 1'b1;
        end else begin
          cmd.count_dec = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_F_SCAN: begin
        if (sts.blk_hit) begin
          cmd.blk_take = 1'b1;
          state_next   = S_F_POS;
        end else if (sts.idx_last_blk) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_UNKNOWN;
          state_next     = S_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_F_POS: begin
        if (sts.idx_lt_count && sts.start_le_s) begin
          cmd.prev_take = 1'b1;
          cmd.idx_inc   = 1'b1;
        end else if (sts.idx_nz && sts.left_adj) begin
          cmd.merge_left = 1'b1;
          state_next     = S_F_MERGE;
        end else if (sts.idx_lt_count && sts.right_adj) begin
          cmd.merge_right = 1'b1;
          state_next      = S_OUT;
        end else if (sts.table_full) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_FULL;
          state_next     = S_OUT;
        end else begin
          cmd.shift_start = 1'b1;
          state_next      = S_F_SHIFT;
        end
      end
      S_F_MERGE: begin
        if (sts.idx_lt_count && sts.mid_adj) begin
          cmd.merge_mid = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = S_DROP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_F_SHIFT: begin
        cmd.rd_prev = 1'b1;
        if (sts.idx_gt_pos) begin
          cmd.shift_right = 1'b1;
          cmd.idx_dec     = 1'b1;
        end else begin
          cmd.insert = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/ffra_checker.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator checker
// Port-level properties of the allocator, attached to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] address,
  input logic [4:0]  free_extents
);
  import ffra_pkg::*;

  // A result waiting on a stalled receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(address) && $stable(status))
    else $error("result dropped or changed while stalled");

  // Only a successful request reports an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> address == '0)
    else $error("address set on a failed request");

  // The extent count never exceeds the table.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_extents <= 5'(MAX_EXTENTS))
    else $error("free extent count out of range");

  // An accepted request keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .address      (address),
  .free_extents (free_extents)
);
